/* rtl/ffa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit allocator
// Holds the command codes, result status codes, controller states and the
// search word that travels down the row of block cells.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int SIZE_W = 16;
    localparam int NEED_W = SIZE_W + 3;     // holds five times a size
    localparam int CNT_W  = 11;             // block count, up to 1024 blocks
    localparam int IDX_W  = CNT_W - 1;      // block index, up to 1023
    localparam int OIDX_W = 6;              // index width on the result port
    localparam int STAT_W = 2;

    // reciprocal of five: (x * FIFTH_MUL) >> FIFTH_SHIFT == x / 5 for 16-bit x
    localparam logic [SIZE_W-1:0] FIFTH_MUL   = 16'd52429;
    localparam int                FIFTH_SHIFT = 18;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_OUT
    } t_state;

    // search word handed from cell to cell
    typedef struct packed {
        logic              vld;
        t_cmd              cmd;
        logic [SIZE_W-1:0] size;
        logic [NEED_W-1:0] need5;
        logic [CNT_W-1:0]  count;    // blocks in use when the word was issued
        logic              full;     // table full at issue
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic              split;
        logic              dropped;
        logic              wr_pend;  // cell at index count takes wr_val
        logic [SIZE_W-1:0] wr_val;
    } t_word;

endpackage
`default_nettype wire

/* rtl/ffa_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_cell: one block of the free-space table
// Holds the free count of one block, checks the passing search word for a
// first fit, serves the request and splits off a fifth, and takes the value
// of an appended or split-off block when the word addresses it.
// ----------------------------------------------------------------------------
module ffa_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ffa_pkg::t_word i_word,
    output ffa_pkg::t_word     o_word
);
    import ffa_pkg::*;

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_W-1:0]   r_free;
    t_word               r_word;
    t_word               n_word;
    logic                w_hit;
    logic                w_big;
    logic                w_split;
    logic                w_target;
    logic [2*SIZE_W-1:0] w_prod;
    logic [SIZE_W-1:0]   w_fifth;
    logic [SIZE_W-1:0]   w_after;

    always_comb begin
        w_hit    = i_word.vld && (i_word.cmd == CMD_REQUEST) && !i_word.found &&
                   (MY_CNT < i_word.count) && (r_free >= i_word.size);
        w_big    = {{(NEED_W-SIZE_W){1'b0}}, r_free} >= i_word.need5;
        w_split  = w_hit && w_big && !i_word.full;
        w_target = i_word.vld && i_word.wr_pend && (i_word.count == MY_CNT);
        w_prod   = r_free * FIFTH_MUL;
        w_fifth  = SIZE_W'(w_prod >> FIFTH_SHIFT);
        w_after  = r_free - (w_split ? w_fifth : '0) - i_word.size;

        n_word = i_word;
        if (w_hit) begin
            n_word.found   = 1'b1;
            n_word.idx     = MY_IDX;
            n_word.split   = w_split;
            n_word.dropped = w_big && i_word.full;
            // the new block sits at index count, always further down the row
            n_word.wr_pend = w_split;
            n_word.wr_val  = w_fifth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_free <= w_after;
        end else if (w_target) begin
            r_free <= i_word.wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= n_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.cmd     <= n_word.cmd;
        r_word.size    <= n_word.size;
        r_word.need5   <= n_word.need5;
        r_word.count   <= n_word.count;
        r_word.full    <= n_word.full;
        r_word.found   <= n_word.found;
        r_word.idx     <= n_word.idx;
        r_word.split   <= n_word.split;
        r_word.dropped <= n_word.dropped;
        r_word.wr_pend <= n_word.wr_pend;
        r_word.wr_val  <= n_word.wr_val;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

/* rtl/first_fit_allocator_with_split.sv */
`default_nettype none
// Only one word is in flight at a time; a new word is accepted only once the
// result of the last one has been taken. The search word walks the row of
// cells one block per cycle.
// Reset: synchronous, active low; empties the table and drops any word in
// flight. Block contents are not cleared and read only once appended.
// ----------------------------------------------------------------------------
// first_fit_allocator_with_split: first-fit allocator with fifth split
// A row of block cells keeps the free-space table; a controller issues one
// search word per command, collects it at the end of the row and forms the
// result and the new block count.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_split #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [ffa_pkg::SIZE_W-1:0]    i_size,
    input  wire logic                          i_end_of_batch,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [ffa_pkg::STAT_W-1:0]         o_status,
    output logic [ffa_pkg::OIDX_W-1:0]         o_block_index,
    output logic                               o_split_made,
    output logic                               o_split_dropped,
    output logic [ffa_pkg::OIDX_W-1:0]         o_new_block_index
);
    import ffa_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_eob;
    t_word             r_issue;
    t_word             n_issue;
    t_word             w_chain [MAX_BLOCKS+1];
    t_word             w_last;
    logic              w_in_acc;
    logic              w_full;
    logic              w_done;
    logic [STAT_W-1:0] r_status;
    logic [OIDX_W-1:0] r_idx;
    logic              r_split;
    logic              r_dropped;
    logic [OIDX_W-1:0] r_newidx;
    logic [STAT_W-1:0] n_status;
    logic [OIDX_W-1:0] n_idx;
    logic [OIDX_W-1:0] n_newidx;

    assign w_chain[0] = r_issue;

    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        ffa_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_chain[k]),
            .o_word  (w_chain[k+1])
        );
    end

    assign w_last = w_chain[MAX_BLOCKS];

    always_comb begin
        o_ready  = (r_state == ST_IDLE);
        o_valid  = (r_state == ST_OUT);
        w_in_acc = i_valid && o_ready;
        w_full   = (r_count == MAX_CNT);
        w_done   = (r_state == ST_BUSY) && w_last.vld;

        n_issue         = r_issue;
        n_issue.vld     = w_in_acc;
        n_issue.cmd     = t_cmd'(i_cmd);
        n_issue.size    = i_size;
        n_issue.need5   = {3'b000, i_size} + {1'b0, i_size, 2'b00};
        n_issue.count   = CNT_W'(r_count);
        n_issue.full    = w_full;
        n_issue.found   = 1'b0;
        n_issue.idx     = '0;
        n_issue.split   = 1'b0;
        n_issue.dropped = 1'b0;
        n_issue.wr_pend = (t_cmd'(i_cmd) == CMD_APPEND) && !w_full;
        n_issue.wr_val  = i_size;

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_last.vld) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // result and new count from the word leaving the row
        n_status = STAT_DONE;
        n_idx    = '0;
        n_newidx = '0;
        n_count  = r_count;
        case (w_last.cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_APPEND: begin
                if (w_last.full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_idx   = OIDX_W'(r_count);
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REQUEST: begin
                if (!w_last.found) begin
                    n_status = STAT_MISS;
                end else begin
                    n_idx = OIDX_W'(w_last.idx);
                end
                if (w_last.split) begin
                    n_newidx = OIDX_W'(r_count);
                end
                if (r_eob) begin
                    n_count = '0;
                end else if (w_last.split) begin
                    n_count = r_count + CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue.vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue.vld <= n_issue.vld;
            if (w_done) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_issue.cmd     <= n_issue.cmd;
            r_issue.size    <= n_issue.size;
            r_issue.need5   <= n_issue.need5;
            r_issue.count   <= n_issue.count;
            r_issue.full    <= n_issue.full;
            r_issue.found   <= n_issue.found;
            r_issue.idx     <= n_issue.idx;
            r_issue.split   <= n_issue.split;
            r_issue.dropped <= n_issue.dropped;
            r_issue.wr_pend <= n_issue.wr_pend;
            r_issue.wr_val  <= n_issue.wr_val;
            r_eob           <= i_end_of_batch;
        end
        if (w_done) begin
            r_status  <= n_status;
            r_idx     <= n_idx;
            r_split   <= (w_last.cmd == CMD_REQUEST) && w_last.split;
            r_dropped <= (w_last.cmd == CMD_REQUEST) && w_last.dropped;
            r_newidx  <= n_newidx;
        end
    end

    assign o_status          = r_status;
    assign o_block_index     = r_idx;
    assign o_split_made      = r_split;
    assign o_split_dropped   = r_dropped;
    assign o_new_block_index = r_newidx;

endmodule
`default_nettype wire

/* tb/first_fit_allocator_with_split_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_allocator_with_split_tb: self-checking bench of the allocator
// Runs a short table of directed words, then random batches, some of which
// grow the block table to full and beyond. Every accepted word is scored
// against a local first-fit model or its typed result, checked in order.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_split_tb;
    import ffa_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int N_ITEMS     = 1500;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT    = 900;
    localparam int QUIET_FROM  = 600;
    localparam int QUIET_TO    = 800;
    localparam int IDLE_PCT    = 22;
    localparam int MAX_REPORTS = 10;

    localparam int BATCH_MIX   = 0;
    localparam int BATCH_FILL  = 1;
    localparam int BATCH_NOISE = 2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OIDX_W-1:0] block_index;
        logic              split_made;
        logic              split_dropped;
        logic [OIDX_W-1:0] new_block_index;
    } t_alloc_result;

    typedef struct {
        t_cmd              cmd;
        logic [SIZE_W-1:0] size;
        logic              eob;
        bit                typed;
        t_alloc_result     res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [1:0] i_cmd = 2'd0;
    logic [SIZE_W-1:0] i_size = '0;
    logic i_end_of_batch = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    logic [STAT_W-1:0] o_status;
    logic [OIDX_W-1:0] o_block_index;
    logic o_split_made;
    logic o_split_dropped;
    logic [OIDX_W-1:0] o_new_block_index;

    // local copy of the free-space table
    logic [SIZE_W-1:0] tbl_free [TABLE_DEPTH];
    int                tbl_count = 0;

    t_alloc_result pending_results [$];
    t_stim_row     directed_rows [$];

    int  sent_cnt = 0;
    int  errors = 0;
    int  n_split = 0;
    int  n_dropped = 0;
    int  n_full = 0;
    int  n_miss = 0;
    int  n_results = 0;
    bit  drain_done = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    wire quiet = (sent_cnt >= QUIET_FROM) && (sent_cnt < QUIET_TO);

    first_fit_allocator_with_split #(
        .MAX_BLOCKS(TABLE_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_size            (i_size),
        .i_end_of_batch    (i_end_of_batch),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_block_index     (o_block_index),
        .o_split_made      (o_split_made),
        .o_split_dropped   (o_split_dropped),
        .o_new_block_index (o_new_block_index)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_alloc_result mk_result(logic [STAT_W-1:0] st, int idx, bit split,
                                                bit dropped, int new_idx);
        t_alloc_result r;
        r.status          = st;
        r.block_index     = idx[OIDX_W-1:0];
        r.split_made      = split;
        r.split_dropped   = dropped;
        r.new_block_index = new_idx[OIDX_W-1:0];
        return r;
    endfunction

    // first-fit step: updates the local table, returns the result word
    function automatic t_alloc_result first_fit_step(t_cmd cmd, logic [SIZE_W-1:0] size,
                                                     logic eob);
        t_alloc_result     r;
        logic [NEED_W-1:0] need5;
        logic [SIZE_W-1:0] f;
        logic [SIZE_W-1:0] fifth;
        bit                found;
        r = '0;
        found = 1'b0;
        need5 = NEED_W'(size) * NEED_W'(5);
        case (cmd)
            CMD_CLEAR: begin
                tbl_count = 0;
            end
            CMD_APPEND: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    r.block_index = tbl_count[OIDX_W-1:0];
                    tbl_free[tbl_count] = size;
                    tbl_count++;
                end
            end
            CMD_REQUEST: begin
                for (int b = 0; b < tbl_count; b++) begin
                    if (!found && tbl_free[b] >= size) begin
                        found = 1'b1;
                        r.block_index = b[OIDX_W-1:0];
                        f = tbl_free[b];
                        if ({3'b000, f} >= need5) begin
                            if (tbl_count < TABLE_DEPTH) begin
                                fifth = f / 5;
                                r.new_block_index = tbl_count[OIDX_W-1:0];
                                tbl_free[tbl_count] = fifth;
                                tbl_count++;
                                f = f - fifth;
                                r.split_made = 1'b1;
                            end else begin
                                r.split_dropped = 1'b1;
                            end
                        end
                        tbl_free[b] = f - size;
                    end
                end
                if (!found) r.status = STAT_MISS;
                if (eob) tbl_count = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_append_size();
        case ($urandom_range(0, 3))
            0: return SIZE_W'($urandom_range(0, 65535));
            1: return SIZE_W'($urandom_range(0, 255));
            2: return SIZE_W'($urandom_range(60000, 65535));
            default: return SIZE_W'($urandom_range(0, 4000));
        endcase
    endfunction

    // aim most requests at a live block so they hit, split or just miss
    function automatic logic [SIZE_W-1:0] pick_request_size();
        int                b;
        logic [SIZE_W-1:0] f;
        if (tbl_count == 0 || $urandom_range(0, 9) < 2)
            return SIZE_W'($urandom_range(0, 65535));
        b = $urandom_range(0, tbl_count - 1);
        f = tbl_free[b];
        case ($urandom_range(0, 4))
            0: return f;
            1: return f / 5;
            2: return SIZE_W'($urandom_range(0, f));
            3: return (f == '1) ? f : f + 1'b1;
            default: return SIZE_W'($urandom_range(0, f / 5 + 1));
        endcase
    endfunction

    task automatic add_row(t_cmd c, logic [SIZE_W-1:0] sz, logic eob, bit typed,
                           t_alloc_result res);
        t_stim_row row;
        row.cmd   = c;
        row.size  = sz;
        row.eob   = eob;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    // offer one word, wait for it to be taken, then score it
    task automatic send_word(t_cmd c, logic [SIZE_W-1:0] sz, logic eob, bit typed,
                             t_alloc_result typed_res);
        int            gap;
        bit            drain;
        t_alloc_result predicted;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        drain = !drain_done && sent_cnt >= DRAIN_AT;
        if (drain && gap == 0) gap = 1;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                while (pending_results.size() != 0) @(posedge i_clk);
                drain_done = 1'b1;
            end
        end
        i_valid        <= 1'b1;
        i_cmd          <= c;
        i_size         <= sz;
        i_end_of_batch <= eob;
        // o_ready is settled mid-cycle; the word moves at the next rising edge
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        predicted = first_fit_step(c, sz, eob);
        pending_results.push_back(typed ? typed_res : predicted);
        sent_cnt++;
    endtask

    // receiver: random stalls, one long hold-off, and a quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(negedge i_clk) begin : result_check
        t_alloc_result got;
        t_alloc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.status          = o_status;
            got.block_index     = o_block_index;
            got.split_made      = o_split_made;
            got.split_dropped   = o_split_dropped;
            got.new_block_index = o_new_block_index;
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result word with nothing expected: st=%0d idx=%0d", got.status,
                             got.block_index);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"mismatch on result %0d: exp st=%0d idx=%0d sp=%0b dr=%0b ",
                                  "new=%0d, got st=%0d idx=%0d sp=%0b dr=%0b new=%0d"},
                                 n_results, want.status, want.block_index, want.split_made,
                                 want.split_dropped, want.new_block_index, got.status,
                                 got.block_index, got.split_made, got.split_dropped,
                                 got.new_block_index);
                end
                if (want.split_made) n_split++;
                if (want.split_dropped) n_dropped++;
                if (want.status == STAT_FULL) n_full++;
                if (want.status == STAT_MISS) n_miss++;
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        int        kind;
        int        len;
        int        r;
        bit        first_batch;
        first_batch = 1'b1;

        // empty table, extremes, unused command and end of batch
        add_row(CMD_REQUEST, 16'd5,     1'b0, 1'b1, mk_result(STAT_MISS, 0, 0, 0, 0));
        add_row(CMD_APPEND,  16'hFFFF,  1'b0, 1'b1, mk_result(STAT_DONE, 0, 0, 0, 0));
        add_row(CMD_REQUEST, 16'd0,     1'b0, 1'b1, mk_result(STAT_DONE, 0, 1, 0, 1));
        add_row(CMD_APPEND,  16'd0,     1'b0, 1'b1, mk_result(STAT_DONE, 2, 0, 0, 0));
        add_row(CMD_REQUEST, 16'hFFFF,  1'b0, 1'b1, mk_result(STAT_MISS, 0, 0, 0, 0));
        add_row(CMD_REQUEST, 16'd13108, 1'b0, 1'b0, '0);
        add_row(CMD_REQUEST, 16'd1,     1'b0, 1'b0, '0);
        add_row(CMD_NONE,    16'hFFFF,  1'b1, 1'b1, mk_result(STAT_DONE, 0, 0, 0, 0));
        add_row(CMD_APPEND,  16'd100,   1'b1, 1'b0, '0);
        add_row(CMD_REQUEST, 16'd100,   1'b1, 1'b0, '0);
        add_row(CMD_REQUEST, 16'd0,     1'b0, 1'b1, mk_result(STAT_MISS, 0, 0, 0, 0));
        add_row(CMD_APPEND,  16'd1,     1'b0, 1'b1, mk_result(STAT_DONE, 0, 0, 0, 0));
        add_row(CMD_CLEAR,   16'hAAAA,  1'b1, 1'b1, mk_result(STAT_DONE, 0, 0, 0, 0));
        add_row(CMD_APPEND,  16'd5,     1'b0, 1'b1, mk_result(STAT_DONE, 0, 0, 0, 0));
        add_row(CMD_REQUEST, 16'd1,     1'b0, 1'b0, '0);
        add_row(CMD_REQUEST, 16'd3,     1'b0, 1'b0, '0);
        add_row(CMD_REQUEST, 16'd2,     1'b0, 1'b0, '0);
        add_row(CMD_CLEAR,   16'h5555,  1'b0, 1'b1, mk_result(STAT_DONE, 0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_word(row.cmd, row.size, row.eob, row.typed, row.res);
        end

        while (sent_cnt < N_ITEMS) begin
            r = $urandom_range(0, 99);
            kind = first_batch ? BATCH_FILL :
                   (r < 72) ? BATCH_MIX : (r < 88) ? BATCH_FILL : BATCH_NOISE;
            first_batch = 1'b0;
            case (kind)
                BATCH_FILL: begin
                    // grow to full, overflow it, then force dropped splits
                    send_word(CMD_CLEAR, SIZE_W'($urandom), 1'b0, 1'b0, '0);
                    while (tbl_count < TABLE_DEPTH) begin
                        if ($urandom_range(0, 99) < 70)
                            send_word(CMD_APPEND, pick_append_size(), $urandom_range(0, 1),
                                      1'b0, '0);
                        else
                            send_word(CMD_REQUEST, pick_request_size(), 1'b0, 1'b0, '0);
                    end
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_APPEND, pick_append_size(), 1'b0, 1'b0, '0);
                    send_word(CMD_REQUEST, 16'd0, 1'b0, 1'b0, '0);
                    repeat ($urandom_range(2, 6))
                        send_word(CMD_REQUEST, pick_request_size(), 1'b0, 1'b0, '0);
                    send_word(CMD_REQUEST, pick_request_size(), $urandom_range(0, 1), 1'b0,
                              '0);
                end
                BATCH_NOISE: begin
                    repeat ($urandom_range(3, 10))
                        send_word(t_cmd'($urandom_range(0, 3)), SIZE_W'($urandom),
                                  $urandom_range(0, 1), 1'b0, '0);
                end
                default: begin
                    if ($urandom_range(0, 1))
                        send_word(CMD_CLEAR, SIZE_W'($urandom), $urandom_range(0, 1), 1'b0,
                                  '0);
                    len = $urandom_range(5, 40);
                    repeat (len) begin
                        r = $urandom_range(0, 99);
                        if (r < 40)
                            send_word(CMD_APPEND, pick_append_size(),
                                      $urandom_range(0, 9) == 0, 1'b0, '0);
                        else if (r < 86)
                            send_word(CMD_REQUEST, pick_request_size(), 1'b0, 1'b0, '0);
                        else if (r < 91)
                            send_word(CMD_CLEAR, SIZE_W'($urandom), $urandom_range(0, 1),
                                      1'b0, '0);
                        else if (r < 94)
                            send_word(CMD_NONE, SIZE_W'($urandom), $urandom_range(0, 1),
                                      1'b0, '0);
                        else
                            send_word(CMD_REQUEST, pick_request_size(), 1'b1, 1'b0, '0);
                    end
                end
            endcase
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);

        $display("covered %0d words, %0d results: %0d splits, %0d dropped splits",
                 sent_cnt, n_results, n_split, n_dropped);
        $display("table-full appends %0d, unallocated requests %0d, mismatches %0d",
                 n_full, n_miss, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/first_fit_allocator_with_split.sv
tb/first_fit_allocator_with_split_tb.sv
